[rtl/core/pdd_pkg.sv]
package pdd_pkg;

    // Field and datapath widths.
    localparam int POS_W     = 24;
    localparam int ERR_W     = POS_W + 1;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int INT_W     = 40;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 8;
    localparam int PID_W     = 16;
    localparam int TOL_W     = 16;
    localparam int DUTY_W    = 8;
    localparam int SPD_W     = 32;

    // The multiplier operand is as wide as the integral, which is the widest operand.
    localparam int OPD_W  = INT_W;
    // Three products summed: two guard bits above the widest product.
    localparam int SUM_W  = OPD_W + GAIN_W + 2;
    // The speed dividend is a position change times 20, which needs five more bits.
    localparam int DIV_W  = ERR_W + 5;
    localparam int DVS_W  = DUTY_W;
    localparam int MCNT_W = $clog2(GAIN_W);
    localparam int DCNT_W = $clog2(DIV_W);

    localparam logic [DVS_W-1:0] DUTY_FULL = DVS_W'(255);
    localparam logic [DVS_W-1:0] SPEED_DIV = DVS_W'(9);

    localparam logic [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

    localparam logic [SUM_W-1:0] SUM_FRAC_MASK = SUM_W'((1 << GAIN_FRAC) - 1);
    localparam logic signed [SUM_W-1:0] SUM_PID_MAX = SUM_W'((1 << (PID_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SUM_PID_MIN = -SUM_PID_MAX - SUM_W'(1);

    // Register defaults.
    localparam logic [TOL_W-1:0]  TOL_RST  = TOL_W'(25);
    localparam logic [DUTY_W-1:0] OFFD_RST = DUTY_W'(107);
    localparam logic [DUTY_W-1:0] OFFU_RST = DUTY_W'(120);

    // Configuration port.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = CFG_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_GAIN_P   = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I   = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D   = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_TOL      = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_OFF_DOWN = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_OFF_UP   = REG_IDX_W'(5);

    typedef struct packed {
        logic start;
        logic keep;
    } pdd_mac_cmd_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } pdd_div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pdd_unit_stat_t;

endpackage

[rtl/core/pdd_tick_if.sv]
interface pdd_tick_if import pdd_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic                    start_req;
    logic signed [POS_W-1:0] target_position;
    logic signed [POS_W-1:0] measured_position;

    modport source (
        output valid,
        output start_req,
        output target_position,
        output measured_position,
        input  ready
    );

    modport sink (
        input  valid,
        input  start_req,
        input  target_position,
        input  measured_position,
        output ready
    );

endinterface

[rtl/core/pdd_result_if.sv]
interface pdd_result_if import pdd_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic                    direction;
    logic [DUTY_W-1:0]       duty;
    logic signed [PID_W-1:0] pid_value;
    logic signed [SPD_W-1:0] speed_rpm;
    logic                    done_res;

    modport source (
        output valid,
        output direction,
        output duty,
        output pid_value,
        output speed_rpm,
        output done_res,
        input  ready
    );

    modport sink (
        input  valid,
        input  direction,
        input  duty,
        input  pid_value,
        input  speed_rpm,
        input  done_res,
        output ready
    );

endinterface

[rtl/core/position_pid_deadband_drive_top.sv]
// Channel   Direction  Handshake              Carries
// tick      in         valid/ready            start_req, target_position, measured_position
// result    out        valid/ready            direction, duty, pid_value, speed_rpm, done_res
// apb       in         psel/penable, pready=1 gains, tolerance, deadband offsets
//
// One request is worked on at a time. A tick inside the tolerance band finishes sooner
// than any other, as it skips the deadband scaling and the duty division. The serial
// multiplier runs 16 steps for each of the three PID terms and again for the deadband
// scaling; the serial divider takes 30 steps for the speed estimate, again for the duty.
// Reset is asynchronous and active low; it clears the controller state and loads the
// register defaults. A result that is not taken holds the next request in its last step,
// and a new request is taken only once the previous one has left the datapath.
module position_pid_deadband_drive_top import pdd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    pdd_tick_if.sink              tick,
    pdd_result_if.source          result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_INTEG,
        S_LOAD,
        S_MAC,
        S_SCALE,
        S_DLOAD,
        S_DMAC,
        S_DSTART,
        S_DDIV,
        S_FINISH
    } state_t;

    typedef enum logic {
        OWN_SPEED,
        OWN_DUTY
    } owner_t;

    // The three PID terms are accumulated in this order.
    localparam logic [1:0] PASS_P = 2'd0;
    localparam logic [1:0] PASS_I = 2'd1;
    localparam logic [1:0] PASS_D = 2'd2;

    // Configuration registers.
    logic [GAIN_W-1:0] gain_p_reg;
    logic [GAIN_W-1:0] gain_i_reg;
    logic [GAIN_W-1:0] gain_d_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [DUTY_W-1:0] offd_reg;
    logic [DUTY_W-1:0] offu_reg;
    logic              cfg_wr;

    // Controller state and working registers.
    state_t            state_reg, state_next;
    owner_t            owner_reg, owner_next;
    logic [POS_W-1:0]  tgt_reg, tgt_next;
    logic [POS_W-1:0]  meas_reg, meas_next;
    logic [ERR_W-1:0]  err_reg, err_next;
    logic [ERR_W-1:0]  delta_reg, delta_next;
    logic [DIFF_W-1:0] diff_reg, diff_next;
    logic [INT_W-1:0]  integ_reg, integ_next;
    logic [ERR_W-1:0]  prev_err_reg, prev_err_next;
    logic [POS_W-1:0]  prev_pos_reg, prev_pos_next;
    logic              band_reg, band_next;
    logic [1:0]        pass_reg, pass_next;
    logic [PID_W-1:0]  pid_reg, pid_next;
    logic              dir_reg, dir_next;
    logic [DUTY_W-1:0] off_reg, off_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic [SPD_W-1:0]  speed_reg, speed_next;
    logic              spd_neg_reg, spd_neg_next;

    // Output register, which parts the datapath from the result channel.
    logic              res_valid_reg, res_valid_next;
    logic              res_dir_reg, res_dir_next;
    logic [DUTY_W-1:0] res_duty_reg, res_duty_next;
    logic [PID_W-1:0]  res_pid_reg, res_pid_next;
    logic [SPD_W-1:0]  res_speed_reg, res_speed_next;
    logic              res_done_reg, res_done_next;

    // Shared arithmetic units.
    pdd_mac_cmd_t            mac_cmd;
    pdd_unit_stat_t          mac_stat;
    logic signed [OPD_W-1:0] mac_operand;
    logic signed [GAIN_W-1:0] mac_gain;
    logic signed [SUM_W-1:0] mac_acc;
    pdd_div_cmd_t            div_cmd;
    pdd_unit_stat_t          div_stat;
    logic [DIV_W-1:0]        div_quotient;

    // Combinational helpers.
    logic [INT_W:0]          integ_sum;
    logic [INT_W-1:0]        integ_sat;
    logic [ERR_W-1:0]        err_mag;
    logic [ERR_W-1:0]        delta_mag;
    logic [DIV_W-1:0]        delta_ext;
    logic [DIV_W-1:0]        spd_dividend;
    logic [SUM_W-1:0]        sc_round;
    logic signed [SUM_W-1:0] sc_adj;
    logic signed [SUM_W-1:0] sc_q;
    logic signed [SUM_W-1:0] sc_clip;
    logic [PID_W:0]          pid_ext;
    logic [PID_W:0]          pid_mag;
    logic [DUTY_W-1:0]       off_sel;
    logic [DIV_W:0]          duty_sum;
    logic [DIV_W:0]          duty_full_ext;
    logic [DUTY_W-1:0]       duty_clamp;
    logic [SPD_W-1:0]        spd_mag;
    logic                    res_free;

    // ------------------------------------------------------------------
    // Configuration port. The register index is taken from the word address.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            tol_reg    <= TOL_RST;
            offd_reg   <= OFFD_RST;
            offu_reg   <= OFFU_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[CFG_ADDR_W-1:2])
                REG_GAIN_P:   gain_p_reg <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:   gain_i_reg <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:   gain_d_reg <= pwdata[GAIN_W-1:0];
                REG_TOL:      tol_reg    <= pwdata[TOL_W-1:0];
                REG_OFF_DOWN: offd_reg   <= pwdata[DUTY_W-1:0];
                REG_OFF_UP:   offu_reg   <= pwdata[DUTY_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[CFG_ADDR_W-1:2])
            REG_GAIN_P:   prdata = {{(CFG_DATA_W-GAIN_W){1'b0}}, gain_p_reg};
            REG_GAIN_I:   prdata = {{(CFG_DATA_W-GAIN_W){1'b0}}, gain_i_reg};
            REG_GAIN_D:   prdata = {{(CFG_DATA_W-GAIN_W){1'b0}}, gain_d_reg};
            REG_TOL:      prdata = {{(CFG_DATA_W-TOL_W){1'b0}}, tol_reg};
            REG_OFF_DOWN: prdata = {{(CFG_DATA_W-DUTY_W){1'b0}}, offd_reg};
            REG_OFF_UP:   prdata = {{(CFG_DATA_W-DUTY_W){1'b0}}, offu_reg};
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Arithmetic units. The multiplier forms the three PID products into
    // one accumulator and later scales the PID magnitude by the deadband
    // span; the divider serves the speed estimate and the duty.
    // ------------------------------------------------------------------
    pdd_smac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mac_cmd),
        .operand (mac_operand),
        .gain    (mac_gain),
        .stat    (mac_stat),
        .acc     (mac_acc)
    );

    pdd_sdiv u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // ------------------------------------------------------------------
    // Datapath helpers.
    // ------------------------------------------------------------------

    // The integral saturates when the carry into the sign bit disagrees with the carry out.
    assign integ_sum = {integ_reg[INT_W-1], integ_reg}
                     + {{(INT_W+1-ERR_W){err_reg[ERR_W-1]}}, err_reg};
    assign integ_sat = (integ_sum[INT_W] != integ_sum[INT_W-1])
                     ? (integ_sum[INT_W] ? INT_MIN : INT_MAX)
                     : integ_sum[INT_W-1:0];

    assign err_mag   = err_reg[ERR_W-1] ? (~err_reg + 1'b1) : err_reg;
    assign delta_mag = delta_reg[ERR_W-1] ? (~delta_reg + 1'b1) : delta_reg;
    assign delta_ext = {{(DIV_W-ERR_W){1'b0}}, delta_mag};
    // Times 20 as a sum of two shifts; the sign is put back after the division.
    assign spd_dividend = (delta_ext << 4) + (delta_ext << 2);

    // Division by the Q8.8 scale, truncated towards zero, then the 16-bit clamp.
    assign sc_round = mac_acc[SUM_W-1] ? SUM_FRAC_MASK : '0;
    assign sc_adj   = mac_acc + $signed(sc_round);
    assign sc_q     = sc_adj >>> GAIN_FRAC;
    assign sc_clip  = (sc_q > SUM_PID_MAX) ? SUM_PID_MAX
                    : ((sc_q < SUM_PID_MIN) ? SUM_PID_MIN : sc_q);

    assign pid_ext = {pid_reg[PID_W-1], pid_reg};
    assign pid_mag = pid_reg[PID_W-1] ? (~pid_ext + 1'b1) : pid_ext;
    assign off_sel = pid_reg[PID_W-1] ? offd_reg : offu_reg;

    assign duty_full_ext = {{(DIV_W+1-DUTY_W){1'b0}}, DUTY_FULL};
    assign duty_sum      = {{(DIV_W+1-DUTY_W){1'b0}}, off_reg} + {1'b0, div_quotient};
    assign duty_clamp    = (duty_sum > duty_full_ext) ? DUTY_FULL : duty_sum[DUTY_W-1:0];

    assign spd_mag  = {{(SPD_W-DIV_W){1'b0}}, div_quotient};
    assign res_free = !res_valid_reg || result.ready;

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        owner_next     = owner_reg;
        tgt_next       = tgt_reg;
        meas_next      = meas_reg;
        err_next       = err_reg;
        delta_next     = delta_reg;
        diff_next      = diff_reg;
        integ_next     = integ_reg;
        prev_err_next  = prev_err_reg;
        prev_pos_next  = prev_pos_reg;
        band_next      = band_reg;
        pass_next      = pass_reg;
        pid_next       = pid_reg;
        dir_next       = dir_reg;
        off_next       = off_reg;
        duty_next      = duty_reg;
        speed_next     = speed_reg;
        spd_neg_next   = spd_neg_reg;
        res_valid_next = res_valid_reg;
        res_dir_next   = res_dir_reg;
        res_duty_next  = res_duty_reg;
        res_pid_next   = res_pid_reg;
        res_speed_next = res_speed_reg;
        res_done_next  = res_done_reg;
        mac_cmd        = '0;
        mac_operand    = '0;
        mac_gain       = '0;
        div_cmd        = '0;

        if (res_valid_reg && result.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (tick.valid)
                begin
                    tgt_next  = tick.target_position;
                    meas_next = tick.measured_position;
                    // A new move forgets everything the previous one left behind.
                    if (tick.start_req)
                    begin
                        integ_next    = '0;
                        prev_err_next = '0;
                        prev_pos_next = '0;
                    end
                    state_next = S_PREP;
                end
            end

            S_PREP:
            begin
                err_next   = {tgt_reg[POS_W-1], tgt_reg} - {meas_reg[POS_W-1], meas_reg};
                delta_next = {meas_reg[POS_W-1], meas_reg}
                           - {prev_pos_reg[POS_W-1], prev_pos_reg};
                state_next = S_INTEG;
            end

            S_INTEG:
            begin
                integ_next = integ_sat;
                diff_next  = {err_reg[ERR_W-1], err_reg}
                           - {prev_err_reg[ERR_W-1], prev_err_reg};
                band_next  = (err_mag < {{(ERR_W-TOL_W){1'b0}}, tol_reg});
                // The speed division runs alongside the PID products.
                div_cmd.start    = 1'b1;
                div_cmd.dividend = spd_dividend;
                div_cmd.divisor  = SPEED_DIV;
                owner_next       = OWN_SPEED;
                spd_neg_next     = delta_reg[ERR_W-1];
                pass_next        = PASS_P;
                state_next       = S_LOAD;
            end

            S_LOAD:
            begin
                mac_cmd.start = 1'b1;
                mac_cmd.keep  = (pass_reg != PASS_P);
                case (pass_reg)
                    PASS_P:
                    begin
                        mac_operand = {{(OPD_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                        mac_gain    = gain_p_reg;
                    end
                    PASS_I:
                    begin
                        mac_operand = integ_reg;
                        mac_gain    = gain_i_reg;
                    end
                    PASS_D:
                    begin
                        mac_operand = {{(OPD_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
                        mac_gain    = gain_d_reg;
                    end
                    default:
                    begin
                        mac_operand = '0;
                        mac_gain    = '0;
                    end
                endcase
                state_next = S_MAC;
            end

            S_MAC:
            begin
                if (mac_stat.done)
                begin
                    if (pass_reg == PASS_D)
                    begin
                        state_next = S_SCALE;
                    end
                    else
                    begin
                        pass_next  = pass_reg + 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end

            S_SCALE:
            begin
                pid_next   = sc_clip[PID_W-1:0];
                dir_next   = 1'b0;
                duty_next  = '0;
                state_next = band_reg ? S_FINISH : S_DLOAD;
            end

            S_DLOAD:
            begin
                // Scale the PID magnitude by the span above the deadband offset.
                dir_next      = pid_reg[PID_W-1];
                off_next      = off_sel;
                mac_cmd.start = 1'b1;
                mac_cmd.keep  = 1'b0;
                mac_operand   = {{(OPD_W-PID_W-1){1'b0}}, pid_mag};
                mac_gain      = {{(GAIN_W-DUTY_W){1'b0}}, DUTY_FULL - off_sel};
                state_next    = S_DMAC;
            end

            S_DMAC:
            begin
                if (mac_stat.done)
                begin
                    state_next = S_DSTART;
                end
            end

            S_DSTART:
            begin
                if (!div_stat.busy && !div_stat.done)
                begin
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = mac_acc[DIV_W-1:0];
                    div_cmd.divisor  = DUTY_FULL;
                    owner_next       = OWN_DUTY;
                    state_next       = S_DDIV;
                end
            end

            S_DDIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!div_stat.busy && !div_stat.done && res_free)
                begin
                    res_valid_next = 1'b1;
                    res_dir_next   = dir_reg;
                    res_duty_next  = duty_reg;
                    res_pid_next   = pid_reg;
                    res_speed_next = speed_reg;
                    res_done_next  = band_reg;
                    // Inside the band the last error and position are kept.
                    if (!band_reg)
                    begin
                        prev_err_next = err_reg;
                        prev_pos_next = meas_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The divider's result goes to whichever quantity started it.
        if (div_stat.done)
        begin
            if (owner_reg == OWN_DUTY)
            begin
                duty_next = duty_clamp;
            end
            else
            begin
                speed_next = spd_neg_reg ? (~spd_mag + 1'b1) : spd_mag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            owner_reg     <= OWN_SPEED;
            tgt_reg       <= '0;
            meas_reg      <= '0;
            err_reg       <= '0;
            delta_reg     <= '0;
            diff_reg      <= '0;
            integ_reg     <= '0;
            prev_err_reg  <= '0;
            prev_pos_reg  <= '0;
            band_reg      <= 1'b0;
            pass_reg      <= PASS_P;
            pid_reg       <= '0;
            dir_reg       <= 1'b0;
            off_reg       <= '0;
            duty_reg      <= '0;
            speed_reg     <= '0;
            spd_neg_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            res_dir_reg   <= 1'b0;
            res_duty_reg  <= '0;
            res_pid_reg   <= '0;
            res_speed_reg <= '0;
            res_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            owner_reg     <= owner_next;
            tgt_reg       <= tgt_next;
            meas_reg      <= meas_next;
            err_reg       <= err_next;
            delta_reg     <= delta_next;
            diff_reg      <= diff_next;
            integ_reg     <= integ_next;
            prev_err_reg  <= prev_err_next;
            prev_pos_reg  <= prev_pos_next;
            band_reg      <= band_next;
            pass_reg      <= pass_next;
            pid_reg       <= pid_next;
            dir_reg       <= dir_next;
            off_reg       <= off_next;
            duty_reg      <= duty_next;
            speed_reg     <= speed_next;
            spd_neg_reg   <= spd_neg_next;
            res_valid_reg <= res_valid_next;
            res_dir_reg   <= res_dir_next;
            res_duty_reg  <= res_duty_next;
            res_pid_reg   <= res_pid_next;
            res_speed_reg <= res_speed_next;
            res_done_reg  <= res_done_next;
        end
    end

    assign tick.ready       = (state_reg == S_IDLE);
    assign result.valid     = res_valid_reg;
    assign result.direction = res_dir_reg;
    assign result.duty      = res_duty_reg;
    assign result.pid_value = res_pid_reg;
    assign result.speed_rpm = res_speed_reg;
    assign result.done_res  = res_done_reg;

`ifndef SYNTHESIS
    // A result inside the band never drives the motor.
    a_band_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.done_res) |-> (result.duty == '0 && !result.direction))
        else $error("in-band result carries a drive value");

    // The multiplier is only restarted once it has finished.
    a_mac_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        mac_cmd.start |-> !mac_stat.busy)
        else $error("multiplier restarted while busy");

    // The divider is only restarted once it has finished.
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_cmd.start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    // An accepted request occupies the datapath for at least the following cycle.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (tick.valid && tick.ready) |=> !tick.ready)
        else $error("second request taken while one is in flight");
`endif

endmodule

[rtl/core/pdd_smac.sv]
// Serial signed multiply-accumulate: one bit of the gain per cycle. The top bit
// of the gain carries negative weight, so the last step subtracts.
module pdd_smac import pdd_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pdd_mac_cmd_t            cmd,
    input  logic signed [OPD_W-1:0] operand,
    input  logic signed [GAIN_W-1:0] gain,
    output pdd_unit_stat_t          stat,
    output logic signed [SUM_W-1:0] acc
);

    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic [SUM_W-1:0]        mcand_reg, mcand_next;
    logic [GAIN_W-1:0]       mplier_reg, mplier_next;
    logic [MCNT_W-1:0]       cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic signed [SUM_W-1:0] addend;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        addend      = mplier_reg[0] ? $signed(mcand_reg) : '0;

        if (cmd.start)
        begin
            mcand_next  = {{(SUM_W-OPD_W){operand[OPD_W-1]}}, operand};
            mplier_next = gain;
            cnt_next    = '0;
            busy_next   = 1'b1;
            if (!cmd.keep)
            begin
                acc_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg == MCNT_W'(GAIN_W - 1))
            begin
                acc_next  = acc_reg - addend;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                acc_next = acc_reg + addend;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            acc_reg    <= acc_next;
            mcand_reg  <= mcand_next;
            mplier_reg <= mplier_next;
            cnt_reg    <= cnt_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
        end
    end

    assign acc       = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[rtl/core/pdd_sdiv.sv]
// Restoring division of an unsigned dividend by a narrow divisor, one quotient
// bit per cycle. The quotient shifts in where the dividend shifts out.
module pdd_sdiv import pdd_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  pdd_div_cmd_t     cmd,
    output pdd_unit_stat_t   stat,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    trial_sub;
    logic              fits;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});

        if (cmd.start)
        begin
            quo_next  = cmd.dividend;
            rem_next  = '0;
            dvs_next  = cmd.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[tb/pdd_drive_checker.sv]
module pdd_drive_checker import pdd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    pdd_tick_if                   tick,
    pdd_result_if                 result,
    output int                    fail_count,
    output int                    expected_left
);

    typedef struct packed {
        logic                    direction;
        logic [DUTY_W-1:0]       duty;
        logic signed [PID_W-1:0] pid_value;
        logic signed [SPD_W-1:0] speed_rpm;
        logic                    done_res;
    } drive_t;

    localparam longint DUTY_TOP  = 255;
    localparam longint SPEED_NUM = 20;
    localparam longint SPEED_DEN = 9;
    localparam longint INTEG_HI  = (longint'(1) <<< (INT_W - 1)) - 1;
    localparam longint INTEG_LO  = -INTEG_HI - 1;
    localparam longint PID_HI    = (longint'(1) <<< (PID_W - 1)) - 1;
    localparam longint PID_LO    = -PID_HI - 1;
    localparam longint SPD_HI    = (longint'(1) <<< (SPD_W - 1)) - 1;
    localparam longint SPD_LO    = -SPD_HI - 1;

    // Mirror of the register file, kept up to date from the bus.
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [TOL_W-1:0]         band;
    logic [DUTY_W-1:0]        off_down;
    logic [DUTY_W-1:0]        off_up;

    // Controller state as the block should hold it.
    logic signed [INT_W-1:0]  integ;
    logic signed [ERR_W-1:0]  last_err;
    logic signed [POS_W-1:0]  last_pos;

    drive_t pending_drives[$];
    int     mismatch_total;
    int     results_seen;

    assign fail_count = mismatch_total;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [DUTY_W-1:0] deadband_duty(longint mag, logic [DUTY_W-1:0] off);
        longint d;
        d = longint'(off) + (mag * (DUTY_TOP - longint'(off))) / DUTY_TOP;
        return (d > DUTY_TOP) ? DUTY_W'(DUTY_TOP) : DUTY_W'(d);
    endfunction

    // Works out the drive command for one tick and advances the controller state.
    function automatic drive_t compute_drive(logic start, logic signed [POS_W-1:0] tgt,
                                             logic signed [POS_W-1:0] meas);
        longint err;
        longint acc;
        longint sum;
        longint pid;
        longint spd;
        longint mag;
        drive_t r;
        if (start) begin
            integ    = '0;
            last_err = '0;
            last_pos = '0;
        end
        spd   = ((longint'(meas) - longint'(last_pos)) * SPEED_NUM) / SPEED_DEN;
        err   = longint'(tgt) - longint'(meas);
        acc   = clamp(longint'(integ) + err, INTEG_LO, INTEG_HI);
        integ = INT_W'(acc);
        sum   = err * longint'(kp) + acc * longint'(ki)
              + (err - longint'(last_err)) * longint'(kd);
        pid   = clamp(sum / (longint'(1) <<< GAIN_FRAC), PID_LO, PID_HI);
        mag   = (err < 0) ? -err : err;
        r.pid_value = PID_W'(pid);
        r.speed_rpm = SPD_W'(clamp(spd, SPD_LO, SPD_HI));
        r.done_res  = (mag < longint'(band));
        r.direction = 1'b0;
        r.duty      = '0;
        if (!r.done_res) begin
            r.direction = (pid < 0);
            r.duty      = deadband_duty(r.direction ? -pid : pid,
                                        r.direction ? off_down : off_up);
            last_err    = ERR_W'(err);
            last_pos    = meas;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] drive mismatch: %s", $realtime, what);
        mismatch_total++;
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor_step
        drive_t want;
        if (!rst_n) begin
            kp       = '0;
            ki       = '0;
            kd       = '0;
            band     = TOL_RST;
            off_down = OFFD_RST;
            off_up   = OFFU_RST;
            integ    = '0;
            last_err = '0;
            last_pos = '0;
            pending_drives.delete();
            mismatch_total = 0;
            results_seen   = 0;
            expected_left <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_GAIN_P:   kp       = pwdata[GAIN_W-1:0];
                    REG_GAIN_I:   ki       = pwdata[GAIN_W-1:0];
                    REG_GAIN_D:   kd       = pwdata[GAIN_W-1:0];
                    REG_TOL:      band     = pwdata[TOL_W-1:0];
                    REG_OFF_DOWN: off_down = pwdata[DUTY_W-1:0];
                    REG_OFF_UP:   off_up   = pwdata[DUTY_W-1:0];
                    default: ;
                endcase
            end

            // Results are retired before new ticks are queued, so that a result can
            // never be matched against a tick accepted at the same edge.
            if (result.valid && result.ready) begin
                results_seen++;
                if (pending_drives.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no tick outstanding",
                                              results_seen));
                end
                else begin
                    want = pending_drives.pop_front();
                    if (result.direction !== want.direction)
                        report_mismatch($sformatf("result %0d direction %0b, expected %0b",
                                                  results_seen, result.direction,
                                                  want.direction));
                    if (result.duty !== want.duty)
                        report_mismatch($sformatf("result %0d duty %0d, expected %0d",
                                                  results_seen, result.duty, want.duty));
                    if (result.pid_value !== want.pid_value)
                        report_mismatch($sformatf("result %0d pid_value %0d, expected %0d",
                                                  results_seen, result.pid_value,
                                                  want.pid_value));
                    if (result.speed_rpm !== want.speed_rpm)
                        report_mismatch($sformatf("result %0d speed_rpm %0d, expected %0d",
                                                  results_seen, result.speed_rpm,
                                                  want.speed_rpm));
                    if (result.done_res !== want.done_res)
                        report_mismatch($sformatf("result %0d done_res %0b, expected %0b",
                                                  results_seen, result.done_res,
                                                  want.done_res));
                end
            end

            if (tick.valid && tick.ready)
                pending_drives.push_back(compute_drive(tick.start_req, tick.target_position,
                                                       tick.measured_position));

            expected_left <= pending_drives.size();
        end
    end

endmodule

[tb/tb_position_pid_deadband_drive_top.sv]
// Top of the testbench for the position controller. It owns the clock, the reset, the
// register bus and both channels. All prediction and comparison live in the checker,
// which watches the same signals and hands back how many mismatches it has seen and
// how many drive commands are still owed by the block.
module tb_position_pid_deadband_drive_top;
    import pdd_pkg::*;

    localparam int POS_HI          = (1 <<< (POS_W - 1)) - 1;
    localparam int POS_LO          = -POS_HI - 1;
    localparam int PHASES          = 10;
    localparam int TICKS_PER_PHASE = 195;
    // Settling time after the last result has been taken; it comfortably covers anything
    // still in flight, even a tick outside the band.
    localparam int SETTLE_CYCLES   = 200;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    expected_left;
    // While set, the sender offers requests back to back with no idle cycles.
    bit                    sender_calm;

    pdd_tick_if   tick_ch ();
    pdd_result_if result_ch ();

    position_pid_deadband_drive_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tick    (tick_ch),
        .result  (result_ch)
    );

    pdd_drive_checker drive_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .tick          (tick_ch),
        .result        (result_ch),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Idle stretches are mostly short, sometimes longer, and now and then long enough
    // to let the block run completely dry or back up completely.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 3);
        if (pick < 95)
            return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic int clamp_pos(longint v);
        if (v > POS_HI)
            return POS_HI;
        if (v < POS_LO)
            return POS_LO;
        return int'(v);
    endfunction

    // Uniform over the whole encoder range, so every bit of a position field toggles.
    function automatic int any_pos();
        logic [POS_W-1:0] r;
        r = POS_W'($urandom);
        return int'($signed(r));
    endfunction

    function automatic int rand_within(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Mostly modest gains, so that the PID value is not pinned at its limits all the
    // time; the rest are zero or drawn from the full signed range.
    function automatic int random_gain();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return 0;
        if (pick < 55)
            return rand_within(600);
        if (pick < 85)
            return rand_within(8000);
        return int'($signed(GAIN_W'($urandom)));
    endfunction

    function automatic int random_tol();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            return 0;
        if (pick < 70)
            return $urandom_range(1, 100);
        if (pick < 90)
            return $urandom_range(0, 65535);
        return 65535;
    endfunction

    function automatic int random_offset();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 0;
        if (pick == 1)
            return 255;
        return $urandom_range(0, 255);
    endfunction

    // Distance scale of a move: from a few counts up to the whole encoder range.
    function automatic int move_span();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(10, 200);
            1:       return $urandom_range(200, 5000);
            2:       return $urandom_range(5000, 200000);
            default: return POS_HI;
        endcase
    endfunction

    // One register write: a setup cycle, then an access cycle that completes at the
    // edge where pready is seen high.
    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Registers are only ever rewritten while the block is idle, so callers drain the
    // tick channel first.
    task automatic apply_settings(int kp, int ki, int kd, int tol, int offd, int offu);
        apb_write(REG_GAIN_P, CFG_DATA_W'(kp));
        apb_write(REG_GAIN_I, CFG_DATA_W'(ki));
        apb_write(REG_GAIN_D, CFG_DATA_W'(kd));
        apb_write(REG_TOL, CFG_DATA_W'(tol));
        apb_write(REG_OFF_DOWN, CFG_DATA_W'(offd));
        apb_write(REG_OFF_UP, CFG_DATA_W'(offu));
    endtask

    // Offers one request and holds it until the block takes it. Valid is left high
    // when the next request follows straight away, so it is never dropped and raised
    // again within the same edge.
    task automatic send_tick(logic start, int tgt, int meas);
        int gap;
        tick_ch.valid             <= 1'b1;
        tick_ch.start_req         <= start;
        tick_ch.target_position   <= POS_W'(tgt);
        tick_ch.measured_position <= POS_W'(meas);
        do @(posedge clk); while (!tick_ch.ready);
        gap = (sender_calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering requests and waits until every drive command owed has been taken.
    // The checker updates its count on the clock edge, hence the step before each look.
    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_left != 0);
    endtask

    // A well-formed move: a start request, then encoder readings that close in on the
    // target with a little jitter, usually ending with a few ticks inside the band.
    // Now and then the start is left off, so the move inherits the previous state.
    task automatic run_move(inout int sent);
        int  span;
        int  tgt;
        int  meas;
        int  steps;
        int  k;
        bit  broken;
        span        = move_span();
        tgt         = clamp_pos(longint'(rand_within(span)));
        meas        = clamp_pos(longint'(tgt) + longint'(rand_within(span)));
        steps       = $urandom_range(2, 28);
        broken      = ($urandom_range(0, 6) == 0);
        sender_calm = ($urandom_range(0, 3) == 0);
        for (k = 0; k < steps; k++)
        begin
            send_tick(k == 0 && !broken, tgt, meas);
            meas = clamp_pos(longint'(meas) + longint'((tgt - meas) / int'($urandom_range(2, 5)))
                             + longint'(rand_within(3)));
            sent++;
        end
    endtask

    // A short burst of unrelated readings across the full range with random start bits.
    task automatic run_noise(inout int sent);
        int n;
        int k;
        n           = $urandom_range(1, 5);
        sender_calm = 1'b0;
        for (k = 0; k < n; k++)
        begin
            send_tick(1'($urandom_range(0, 1)), any_pos(), any_pos());
            sent++;
        end
    endtask

    // Result side: ready is held high for a run of cycles, occasionally a long one with
    // no stalls at all, then dropped for a stall of random length.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            repeat (idle_len()) @(posedge clk);
            result_ch.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(200, 600)) @(posedge clk);
            else
                repeat ($urandom_range(1, 30)) @(posedge clk);
            result_ch.ready <= 1'b0;
        end
    end

    initial
    begin : stimulus
        int phase;
        int sent;

        rst_n                     <= 1'b0;
        psel                      <= 1'b0;
        penable                   <= 1'b0;
        pwrite                    <= 1'b0;
        paddr                     <= '0;
        pwdata                    <= '0;
        tick_ch.valid             <= 1'b0;
        tick_ch.start_req         <= 1'b0;
        tick_ch.target_position   <= '0;
        tick_ch.measured_position <= '0;
        sender_calm = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight out of reset the gains are zero, so the PID value is zero and every
        // tick outside the default band of 25 drives upward at the default up offset.
        send_tick(1'b1, 0, 0);
        send_tick(1'b0, 100, 0);
        send_tick(1'b0, -100, 0);
        wait_drained();

        // Unit proportional gain with small integral and derivative terms: both drive
        // directions, errors either side of the band edge, and the widest errors that
        // push the PID value into saturation at either end.
        apply_settings(256, 16, 128, 25, 107, 120);
        send_tick(1'b1, 1000, 0);
        send_tick(1'b0, 1000, 400);
        send_tick(1'b0, 0, 1000);
        send_tick(1'b0, 24, 0);
        send_tick(1'b0, 25, 0);
        send_tick(1'b0, 0, 24);
        send_tick(1'b0, 0, 25);
        send_tick(1'b0, POS_HI, POS_LO);
        send_tick(1'b0, POS_LO, POS_HI);
        send_tick(1'b1, POS_LO, POS_LO);
        send_tick(1'b0, POS_HI, POS_HI);
        wait_drained();

        // Zero tolerance makes even a zero error an active tick. A negative gain turns
        // a positive error into downward drive; the offsets sit at their extremes.
        apply_settings(-256, 0, 0, 0, 0, 255);
        send_tick(1'b1, 0, 0);
        send_tick(1'b0, 500, 0);
        send_tick(1'b0, -500, 0);
        wait_drained();

        apply_settings(300, 0, -200, 40, 255, 0);
        send_tick(1'b1, -3000, 0);
        send_tick(1'b0, 3000, 0);
        send_tick(1'b0, POS_HI, 0);

        // Random part. Each phase starts from an idle block with fresh settings; the
        // first two phases use the extreme corners of every register.
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            if (phase == 0)
                apply_settings(32767, 32767, 32767, 0, 0, 255);
            else if (phase == 1)
                apply_settings(-32768, -32768, -32768, 65535, 255, 0);
            else
                apply_settings(random_gain(), random_gain(), random_gain(), random_tol(),
                               random_offset(), random_offset());
            sent = 0;
            while (sent < TICKS_PER_PHASE)
            begin
                if ($urandom_range(0, 4) == 0)
                    run_noise(sent);
                else
                    run_move(sent);
                // Occasionally let the block run completely dry mid-phase.
                if ($urandom_range(0, 59) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_left == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: several times the slowest plausible run, including every request
    // meeting the longest stalls on both sides.
    initial
    begin
        #30_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
